// ===== hw/rtl/ces_pkg.sv =====
// Shared types and constants for the counting sort engine.
// Used by every module of the block; depends on nothing.
package ces_pkg;

   localparam int VALUE_W     = 8;
   localparam int MAX_VALUE   = 255;
   localparam int NUM_BINS    = MAX_VALUE + 1;
   localparam int BIN_W       = $clog2(NUM_BINS);
   localparam int MAX_ITEMS   = 1024;
   localparam int COUNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_FETCH = 1'b1
   } ces_op_type;

   typedef struct packed {
      logic               req_type;
      logic [VALUE_W-1:0] value;
   } ces_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] sorted_value;
      logic               last;
      logic               empty_res;
   } ces_rsp_type;

   typedef struct packed {
      ces_op_type         op;
      logic               in_range;
      logic [BIN_W-1:0]   bin;
   } ces_cmd_type;

endpackage

// ===== hw/rtl/ces_front.sv =====
// Front end: accepts request beats into a holding register and classifies them.
// Depends on ces_pkg.
module ces_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ces_pkg::ces_req_type req_data,
   input  logic                 q_full,
   output logic                 cmd_valid,
   output ces_pkg::ces_cmd_type cmd
);
   import ces_pkg::*;

   logic        cmd_valid_ff, cmd_valid_in;
   ces_cmd_type cmd_ff, cmd_in;
   logic        take;

   always_comb begin
      req_stall    = cmd_valid_ff & q_full;
      take         = req_valid & ~req_stall;
      cmd_valid_in = take | (cmd_valid_ff & q_full);
      cmd_in       = cmd_ff;
      if (take) begin
         cmd_in.op       = req_data.req_type ? OP_FETCH : OP_LOAD;
         cmd_in.in_range = (int'(req_data.value) <= MAX_VALUE);
         cmd_in.bin      = BIN_W'(req_data.value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

endmodule

// ===== hw/rtl/ces_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on ces_pkg.
module ces_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  ces_pkg::ces_cmd_type push_cmd,
   output logic                 full,
   output logic                 pop_valid,
   output ces_pkg::ces_cmd_type pop_cmd,
   input  logic                 pop
);
   import ces_pkg::*;

   ces_cmd_type       entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   always_comb begin
      full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      pop_valid = (count_ff != '0);
      pop_cmd   = entries_ff[rd_ptr_ff];
      do_push   = push_valid & ~full;
      do_pop    = pop & pop_valid;
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/ces_back.sv =====
// Back end: histogram memory, nonzero flags, scan pointer and result register.
// Depends on ces_pkg.
module ces_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  ces_pkg::ces_cmd_type q_cmd,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ces_pkg::ces_rsp_type rsp_data
);
   import ces_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD_WR,
      ST_SCAN,
      ST_FETCH_WR
   } state_type;

   state_type           state_ff, state_in;
   logic [NUM_BINS-1:0] nz_ff, nz_in;
   logic [BIN_W-1:0]    scan_ff, scan_in;
   logic [BIN_W-1:0]    work_addr_ff, work_addr_in;
   logic [COUNT_W-1:0]  held_ff, held_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ces_rsp_type         rsp_data_ff, rsp_data_in;

   logic [COUNT_W-1:0]  bin_mem [NUM_BINS];
   logic [COUNT_W-1:0]  rd_data_ff;
   logic [BIN_W-1:0]    rd_addr, wr_addr;
   logic [COUNT_W-1:0]  wr_data;
   logic                mem_we;
   logic                out_free;

   always_comb begin
      state_in     = state_ff;
      nz_in        = nz_ff;
      scan_in      = scan_ff;
      work_addr_in = work_addr_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      rd_addr      = scan_ff;
      wr_addr      = scan_ff;
      wr_data      = rd_data_ff;
      out_free     = ~rsp_valid_ff | ~rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = q_cmd.bin;
            if (q_valid) begin
               if (q_cmd.op == OP_LOAD) begin
                  q_pop = 1'b1;
                  if (q_cmd.in_range && (held_ff < COUNT_W'(MAX_ITEMS))) begin
                     work_addr_in = q_cmd.bin;
                     held_in      = held_ff + COUNT_W'(1);
                     if (q_cmd.bin < scan_ff) begin
                        scan_in = q_cmd.bin;
                     end
                     state_in = ST_LOAD_WR;
                  end
               end else if (out_free) begin
                  q_pop = 1'b1;
                  if (held_ff == '0) begin
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.sorted_value = '0;
                     rsp_data_in.last         = 1'b0;
                     rsp_data_in.empty_res    = 1'b1;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_LOAD_WR: begin
            mem_we               = 1'b1;
            wr_addr              = work_addr_ff;
            wr_data              = nz_ff[work_addr_ff] ? rd_data_ff + COUNT_W'(1)
                                                       : COUNT_W'(1);
            nz_in[work_addr_ff]  = 1'b1;
            state_in             = ST_IDLE;
         end
         ST_SCAN: begin
            if (nz_ff[scan_ff]) begin
               state_in = ST_FETCH_WR;
            end else begin
               scan_in = scan_ff + BIN_W'(1);
            end
         end
         ST_FETCH_WR: begin
            mem_we  = 1'b1;
            wr_data = rd_data_ff - COUNT_W'(1);
            if (rd_data_ff == COUNT_W'(1)) begin
               nz_in[scan_ff] = 1'b0;
            end
            held_in                  = held_ff - COUNT_W'(1);
            rsp_valid_in             = 1'b1;
            rsp_data_in.sorted_value = VALUE_W'(scan_ff);
            rsp_data_in.last         = (held_ff == COUNT_W'(1));
            rsp_data_in.empty_res    = 1'b0;
            if (held_ff == COUNT_W'(1)) begin
               scan_in = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nz_ff        <= '0;
         scan_ff      <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nz_ff        <= nz_in;
         scan_ff      <= scan_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_addr_ff <= work_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // histogram store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= bin_mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/counting_sort_engine.sv =====
// Counting sort engine, top level.
// Depends on ces_pkg, ces_front, ces_queue and ces_back.
//
// Usage:
//   Request channel (req_valid / req_stall / req_data): each beat is either a
//   load (req_type 0), which counts value in a 256-bin histogram, or a fetch
//   (req_type 1), which returns the smallest value held and removes it.
//   Loads beyond 1024 held values are dropped and give no beat.
//   Response channel (rsp_valid / rsp_stall / rsp_data): one beat per fetch,
//   with last set on the final value of the set, or empty_res set (value 0)
//   when nothing is held. Loads give no response.
// Operation:
//   A beat is registered in the front register, then in the queue; the back
//   end decodes it at the queue head and takes the next only when done. A
//   load reads its bin, then writes it back incremented; an empty fetch
//   registers its response directly. A fetch scans bins from the scan pointer,
//   hit bin included, then writes back the decremented count and registers
//   the response. The scan resumes from the last bin emitted or a lower load.
// Reset clears the nonzero flags, count and scan pointer at once, with no
// clearing pass. A stalled response holds its beat; req_stall rises once full.
module counting_sort_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ces_pkg::ces_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ces_pkg::ces_rsp_type rsp_data
);
   import ces_pkg::*;

   logic        cmd_valid;
   ces_cmd_type cmd;
   logic        q_full;
   logic        q_valid;
   ces_cmd_type q_cmd;
   logic        q_pop;

   ces_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   ces_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_valid),
      .push_cmd   (cmd),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_cmd    (q_cmd),
      .pop        (q_pop)
   );

   ces_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/ces_checker.sv =====
// Port-level checks for the counting sort engine, bound to the top level.
// Depends on ces_pkg and counting_sort_engine.
module ces_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input ces_pkg::ces_rsp_type rsp_data
);
   import ces_pkg::*;

   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_res |-> rsp_data.sorted_value == '0 && !rsp_data.last)
      else $error("empty response carries value or last");

   a_last_then_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last && !(req_valid && !req_stall)
      |=> !(rsp_valid && !rsp_data.empty_res && rsp_data.last && $past(rsp_data.last)
            && $stable(rsp_data)))
      else $error("final value repeated");

endmodule

bind counting_sort_engine ces_checker u_ces_checker (.*);
